@@ rtl/core/ring_kv_cache_store_core_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef RING_KV_CACHE_STORE_CORE_MACROS_SVH
`define RING_KV_CACHE_STORE_CORE_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define RKVC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define RKVC_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

@@ rtl/core/rkvc_pkg.sv @@
package rkvc_pkg;

  // Item modes
  localparam logic [1:0] MODE_WRITE   = 2'd0;
  localparam logic [1:0] MODE_READ    = 2'd1;
  localparam logic [1:0] MODE_ADVANCE = 2'd2;
  localparam logic [1:0] MODE_CLEAR   = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_LAYER  = 3'd1;
  localparam logic [2:0] ST_BAD_ELEM   = 3'd2;
  localparam logic [2:0] ST_BAD_OFFSET = 3'd3;
  localparam logic [2:0] ST_INVALID    = 3'd4;

  // Configuration register indexes and port widths
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_LAYERS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ELEMS       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_TOKENS  = 2'd2;

  // Register field widths
  localparam int LAYERS_REG_W = 3;
  localparam int ELEMS_REG_W = 7;
  localparam int TOKENS_REG_W = 9;

  // Register reset values
  localparam int RST_NUM_LAYERS = 4;
  localparam int RST_ELEMS = 64;
  localparam int RST_MAX_TOKENS = 256;

  localparam int WORD_W = 32;

  typedef struct packed {
    logic [1:0]        mode;
    logic [1:0]        layer;
    logic [7:0]        token_offset;
    logic [5:0]        element;
    logic [WORD_W-1:0] key_word;
    logic [WORD_W-1:0] value_word;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [WORD_W-1:0] key_out;
    logic [WORD_W-1:0] value_out;
    logic [8:0]        token_count;
    logic [7:0]        head_slot;
  } rsp_t;

endpackage

@@ rtl/core/ring_kv_cache_store_core.sv @@
// Channel   | Handshake          | Payload            | Notes
// ----------+--------------------+--------------------+-------------------------------
// item in   | start, busy        | req   (req_t)      | transfer when start && !busy
// result    | done               | rsp   (rsp_t)      | one cycle, receiver cannot stall
// config    | cfg_we             | cfg_index/cfg_wdata| write on any edge with cfg_we
//
// One item per cycle; its result shows with done in the cycle after the transfer,
// the latency of the synchronous read of the word RAM. busy never rises.
// Reset clears head, count and valid marks and reloads the registers; the word
// RAM holds whatever it held and is never swept.
module ring_kv_cache_store_core #(
  parameter int LAYERS_MAX = 4,
  parameter int TOKENS_MAX = 256,
  parameter int ELEMS_MAX  = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  rkvc_pkg::req_t                     req,
  output logic                               done,
  output rkvc_pkg::rsp_t                     rsp,
  input  logic                               cfg_we,
  input  logic [rkvc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rkvc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import rkvc_pkg::*;

  localparam int LAYER_W = (LAYERS_MAX > 1) ? $clog2(LAYERS_MAX) : 1;
  localparam int ELEM_W  = (ELEMS_MAX > 1) ? $clog2(ELEMS_MAX) : 1;
  localparam int SLOT_W  = $clog2(TOKENS_MAX);
  localparam int CNT_W   = $clog2(TOKENS_MAX + 1);
  localparam int SUM_W   = CNT_W + 1;
  localparam int ADDR_W  = LAYER_W + SLOT_W + ELEM_W;
  localparam int DATA_W  = 2 * WORD_W;

  localparam logic [LAYERS_REG_W-1:0] RST_LAYERS_EFF =
    LAYERS_REG_W'((RST_NUM_LAYERS > LAYERS_MAX) ? LAYERS_MAX : RST_NUM_LAYERS);
  localparam logic [ELEMS_REG_W-1:0] RST_ELEMS_EFF =
    ELEMS_REG_W'((RST_ELEMS > ELEMS_MAX) ? ELEMS_MAX : RST_ELEMS);
  localparam logic [CNT_W-1:0] RST_TOKENS_EFF =
    CNT_W'((RST_MAX_TOKENS > TOKENS_MAX) ? TOKENS_MAX : RST_MAX_TOKENS);

  // Effective (clamped) configuration
  logic [LAYERS_REG_W-1:0] layers_eff;
  logic [ELEMS_REG_W-1:0]  elems_eff;
  logic [CNT_W-1:0]        tokens_eff;

  // Ring state
  logic [SLOT_W-1:0]     head;
  logic [SLOT_W-1:0]     head_next;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic [TOKENS_MAX-1:0] slot_valid;

  // Request decode
  logic                  accept;
  logic                  layer_bad;
  logic                  elem_bad;
  logic                  offset_bad;
  logic [SUM_W-1:0]      slot_sum;
  logic [SUM_W-1:0]      slot_wrap;
  logic [SLOT_W-1:0]     rd_slot;
  logic [2:0]            status_next;
  logic                  ram_we;
  logic [SLOT_W-1:0]     ram_slot;
  logic [ADDR_W-1:0]     ram_addr;
  logic [DATA_W-1:0]     ram_rdata;
  logic [LAYERS_REG_W-1:0] cfg_layers;
  logic [ELEMS_REG_W-1:0]  cfg_elems;
  logic [TOKENS_REG_W-1:0] cfg_tokens;

  // Result stage
  logic                  rd_ok;
  logic [2:0]            status_q;
  logic [CNT_W-1:0]      count_q;
  logic [SLOT_W-1:0]     head_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign cfg_layers = cfg_wdata[LAYERS_REG_W-1:0];
  assign cfg_elems  = cfg_wdata[ELEMS_REG_W-1:0];
  assign cfg_tokens = cfg_wdata[TOKENS_REG_W-1:0];

  // Register writes, clamped on the way in
  always_ff @(posedge clk) begin
    if (rst) begin
      layers_eff <= RST_LAYERS_EFF;
      elems_eff  <= RST_ELEMS_EFF;
      tokens_eff <= RST_TOKENS_EFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NUM_LAYERS: begin
          layers_eff <= (32'(cfg_layers) > LAYERS_MAX) ? LAYERS_REG_W'(LAYERS_MAX)
                                                       : cfg_layers;
        end
        REG_ELEMS: begin
          elems_eff <= (32'(cfg_elems) > ELEMS_MAX) ? ELEMS_REG_W'(ELEMS_MAX)
                                                    : cfg_elems;
        end
        REG_MAX_TOKENS: begin
          if (cfg_tokens == '0) begin
            tokens_eff <= CNT_W'(1);
          end else if (32'(cfg_tokens) > TOKENS_MAX) begin
            tokens_eff <= CNT_W'(TOKENS_MAX);
          end else begin
            tokens_eff <= CNT_W'(cfg_tokens);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Range checks
  assign layer_bad  = LAYERS_REG_W'(req.layer) >= layers_eff;
  assign elem_bad   = ELEMS_REG_W'(req.element) >= elems_eff;
  assign offset_bad = 32'(req.token_offset) >= 32'(count);

  // Oldest-relative offset to ring slot: for an in-range offset the sum stays below twice the ring length
  assign slot_sum  = SUM_W'(head) + SUM_W'(tokens_eff) - SUM_W'(count)
                   + SUM_W'(req.token_offset);
  assign slot_wrap = (slot_sum >= SUM_W'(tokens_eff)) ? slot_sum - SUM_W'(tokens_eff)
                                                      : slot_sum;
  assign rd_slot   = SLOT_W'(slot_wrap);

  always_comb begin
    priority if (layer_bad) begin
      status_next = ST_BAD_LAYER;
    end else if (elem_bad) begin
      status_next = ST_BAD_ELEM;
    end else if (req.mode == MODE_WRITE) begin
      status_next = ST_OK;
    end else if (offset_bad) begin
      status_next = ST_BAD_OFFSET;
    end else if (!slot_valid[rd_slot]) begin
      status_next = ST_INVALID;
    end else begin
      status_next = ST_OK;
    end
  end

  // Word RAM access: write at head, read at the resolved slot
  assign ram_we   = accept && (req.mode == MODE_WRITE) && !layer_bad && !elem_bad;
  assign ram_slot = (req.mode == MODE_WRITE) ? head : rd_slot;
  assign ram_addr = {LAYER_W'(req.layer), ram_slot, ELEM_W'(req.element)};

  rkvc_word_ram #(
    .ADDR_W(ADDR_W),
    .DATA_W(DATA_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata({req.key_word, req.value_word}),
    .rdata(ram_rdata)
  );

  // Head and count after an advance
  always_comb begin
    head_next  = (CNT_W'(head) + CNT_W'(1) >= tokens_eff) ? '0 : head + SLOT_W'(1);
    count_next = (count < tokens_eff) ? count + CNT_W'(1) : tokens_eff;
  end

  // Ring pointers and valid marks
  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      count      <= '0;
      slot_valid <= '0;
    end else if (cfg_we && cfg_index == REG_MAX_TOKENS) begin
      head       <= '0;
      count      <= '0;
      slot_valid <= '0;
    end else if (accept) begin
      unique case (req.mode)
        MODE_WRITE: begin
          if (ram_we) begin
            slot_valid[head] <= 1'b1;
          end
        end
        MODE_READ: begin
        end
        MODE_ADVANCE: begin
          head  <= head_next;
          count <= count_next;
        end
        MODE_CLEAR: begin
          head       <= '0;
          count      <= '0;
          slot_valid <= '0;
        end
      endcase
    end
  end

  // Capture the result beside the RAM read
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_ok    <= (req.mode == MODE_READ) && (status_next == ST_OK);
      status_q <= ((req.mode == MODE_WRITE) || (req.mode == MODE_READ)) ? status_next
                                                                         : ST_OK;
      unique case (req.mode)
        MODE_ADVANCE: begin
          count_q <= count_next;
          head_q  <= head_next;
        end
        MODE_CLEAR: begin
          count_q <= '0;
          head_q  <= '0;
        end
        default: begin
          count_q <= count;
          head_q  <= head;
        end
      endcase
    end
  end

  // Drive the result; words only for a good read
  always_comb begin
    rsp.status      = status_q;
    rsp.key_out     = rd_ok ? ram_rdata[DATA_W-1:WORD_W] : '0;
    rsp.value_out   = rd_ok ? ram_rdata[WORD_W-1:0] : '0;
    rsp.token_count = 9'(count_q);
    rsp.head_slot   = 8'(head_q);
  end

endmodule

@@ rtl/core/rkvc_word_ram.sv @@
module rkvc_word_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  logic [DATA_W-1:0] wdata,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [(1 << ADDR_W)];

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/core/rkvc_checker.sv @@
`include "ring_kv_cache_store_core_macros.svh"

module rkvc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input rkvc_pkg::req_t                  req,
  input logic                            done,
  input rkvc_pkg::rsp_t                  rsp
);

  import rkvc_pkg::*;

  // Every transfer yields exactly one result in the next cycle
  `RKVC_ASSERT(a_done_follows, clk, rst, (start && !busy) |=> done, "result missing")
  `RKVC_ASSERT(a_done_caused, clk, rst, done |-> $past(start && !busy), "spurious result")

  // A failed item carries no words
  `RKVC_ASSERT(a_zero_words, clk, rst, (done && rsp.status != ST_OK) |-> (rsp.key_out == '0 && rsp.value_out == '0), "words on error")

  // Clear empties the ring
  `RKVC_ASSERT(a_clear_empty, clk, rst, (done && $past(req.mode == MODE_CLEAR)) |-> (rsp.token_count == '0 && rsp.head_slot == '0 && rsp.status == ST_OK), "clear left state")

  // Status stays within the defined codes
  `RKVC_NEVER(a_status_code, clk, rst, done && rsp.status > ST_INVALID, "undefined status")

endmodule

bind ring_kv_cache_store_core rkvc_checker u_rkvc_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .req  (req),
  .done (done),
  .rsp  (rsp)
);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import rkvc_pkg::*;

  localparam int L_MAX = 4;
  localparam int T_MAX = 256;
  localparam int E_MAX = 64;
  localparam int WORDS = L_MAX * T_MAX * E_MAX;

  // Index with no register behind it; the block must ignore writes to it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  // Ring store predictor plus the queue of results still owed by the block
  class kv_scoreboard;
    bit [LAYERS_REG_W-1:0] layers_reg;
    bit [ELEMS_REG_W-1:0]  elems_reg;
    bit [TOKENS_REG_W-1:0] tokens_reg;
    bit                    slot_ok [T_MAX];
    bit [7:0]              head;
    bit [8:0]              count;
    bit [WORD_W-1:0]       key_mem [WORDS];
    bit [WORD_W-1:0]       val_mem [WORDS];
    bit                    word_set [WORDS];
    rsp_t                  expected_q [$];
    int                    errors;
    int                    results_seen;
    int                    status_seen [5];

    function new();
      layers_reg = LAYERS_REG_W'(RST_NUM_LAYERS);
      elems_reg  = ELEMS_REG_W'(RST_ELEMS);
      tokens_reg = TOKENS_REG_W'(RST_MAX_TOKENS);
      clear_ring();
    endfunction

    function void clear_ring();
      head  = '0;
      count = '0;
      foreach (slot_ok[i]) slot_ok[i] = 1'b0;
    endfunction

    // Registers past the hardware limits clamp; a zero ring length acts as one
    function int ring_len();
      if (tokens_reg == 0) return 1;
      return (tokens_reg > T_MAX) ? T_MAX : int'(tokens_reg);
    endfunction

    function int layers_used();
      return (layers_reg > L_MAX) ? L_MAX : int'(layers_reg);
    endfunction

    function int elems_used();
      return (elems_reg > E_MAX) ? E_MAX : int'(elems_reg);
    endfunction

    function int word_index(int lay, int slot, int el);
      return (lay * T_MAX + slot) * E_MAX + el;
    endfunction

    // Slot of the token that sits off places after the oldest held one
    function int read_slot(int off);
      int s;
      s = int'(head) + ring_len() - int'(count) + off;
      while (s >= ring_len()) s -= ring_len();
      return s;
    endfunction

    function void write_reg(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
      case (idx)
        REG_NUM_LAYERS: layers_reg = data[LAYERS_REG_W-1:0];
        REG_ELEMS:      elems_reg = data[ELEMS_REG_W-1:0];
        REG_MAX_TOKENS: begin
          tokens_reg = data[TOKENS_REG_W-1:0];
          clear_ring();
        end
        default: ;
      endcase
    endfunction

    // False only for a read that would land on a valid slot whose word was never stored
    function bit read_is_safe(req_t r);
      int s;
      if (r.mode != MODE_READ) return 1'b1;
      if (r.layer >= layers_used() || r.element >= elems_used()) return 1'b1;
      if (r.token_offset >= count) return 1'b1;
      s = read_slot(r.token_offset);
      return !slot_ok[s] || word_set[word_index(r.layer, s, r.element)];
    endfunction

    // Apply one accepted transfer and queue the result it owes
    function void note(req_t r);
      rsp_t e;
      int   s;
      int   a;
      int   m;
      m = ring_len();
      e = '0;
      case (r.mode)
        MODE_WRITE, MODE_READ: begin
          if (r.layer >= layers_used()) begin
            e.status = ST_BAD_LAYER;
          end else if (r.element >= elems_used()) begin
            e.status = ST_BAD_ELEM;
          end else if (r.mode == MODE_WRITE) begin
            a = word_index(r.layer, head, r.element);
            key_mem[a]    = r.key_word;
            val_mem[a]    = r.value_word;
            word_set[a]   = 1'b1;
            slot_ok[head] = 1'b1;
          end else if (r.token_offset >= count) begin
            e.status = ST_BAD_OFFSET;
          end else begin
            s = read_slot(r.token_offset);
            if (!slot_ok[s]) begin
              e.status = ST_INVALID;
            end else begin
              a = word_index(r.layer, s, r.element);
              e.key_out   = key_mem[a];
              e.value_out = val_mem[a];
            end
          end
        end
        MODE_ADVANCE: begin
          head = (int'(head) + 1 >= m) ? 8'd0 : head + 8'd1;
          if (count < m) count = count + 9'd1;
          else count = 9'(m);
        end
        default: clear_ring();
      endcase
      e.token_count = count;
      e.head_slot   = head;
      expected_q.push_back(e);
    endfunction

    function void report(string what, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      errors++;
      if (errors <= 30)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    endfunction

    // Compare one result against the oldest owed one
    function void check(rsp_t got);
      rsp_t e;
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 30)
          $display("%0t: result with no transfer pending, expected none, actual %h",
                   $time, got);
        return;
      end
      e = expected_q.pop_front();
      if (e.status <= ST_INVALID) status_seen[e.status]++;
      if (got.status !== e.status)
        report("status", WORD_W'(e.status), WORD_W'(got.status));
      if (got.key_out !== e.key_out) report("key_out", e.key_out, got.key_out);
      if (got.value_out !== e.value_out) report("value_out", e.value_out, got.value_out);
      if (got.token_count !== e.token_count)
        report("token_count", WORD_W'(e.token_count), WORD_W'(got.token_count));
      if (got.head_slot !== e.head_slot)
        report("head_slot", WORD_W'(e.head_slot), WORD_W'(got.head_slot));
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  req_t                 req;
  logic                 done;
  rsp_t                 rsp;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  kv_scoreboard sb;
  int           idle_pct;
  int           items_sent;
  int           settings_used;

  ring_kv_cache_store_core dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Check every strobed result at the edge that ends its cycle
  always @(posedge clk) begin
    if (!rst && done === 1'b1) sb.check(rsp);
  end

  function automatic req_t make_req(logic [1:0] mode, int lay, int off, int el,
                                    logic [WORD_W-1:0] kw, logic [WORD_W-1:0] vw);
    req_t r;
    r.mode         = mode;
    r.layer        = lay[1:0];
    r.token_offset = off[7:0];
    r.element      = el[5:0];
    r.key_word     = kw;
    r.value_word   = vw;
    return r;
  endfunction

  // Mostly legal layers and elements, now and then any value
  function automatic int pick_layer();
    if (sb.layers_used() == 0 || $urandom_range(99) < 10) return $urandom_range(3);
    return $urandom_range(sb.layers_used() - 1);
  endfunction

  function automatic int pick_elem();
    if (sb.elems_used() == 0 || $urandom_range(99) < 10) return $urandom_range(63);
    return $urandom_range(sb.elems_used() - 1);
  endfunction

  function automatic int pick_offset();
    if (sb.count == 0 || $urandom_range(99) < 15) return $urandom_range(255);
    return $urandom_range(sb.count - 1);
  endfunction

  // Offer one transfer after a random idle gap; start stays high afterwards
  task automatic issue(input req_t r);
    if (!sb.read_is_safe(r)) r.mode = MODE_WRITE;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    sb.note(r);
    items_sent++;
  endtask

  // Hold off new transfers until every owed result is in
  task automatic drain();
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    sb.write_reg(idx, val[CFG_DATA_W-1:0]);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input int nl, input int ne, input int nt);
    drain();
    set_reg(REG_NUM_LAYERS, nl);
    set_reg(REG_ELEMS, ne);
    set_reg(REG_MAX_TOKENS, nt);
    settings_used++;
  endtask

  // Random traffic built from token fills, read bursts, advance runs, clears and noise
  task automatic run_random(input int n_items);
    int          stop_at;
    req_t        r;
    logic [95:0] raw;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      case ($urandom_range(19))
        0, 1, 2, 3, 4, 5: begin
          repeat ($urandom_range(1, 8))
            issue(make_req(MODE_WRITE, pick_layer(), $urandom_range(255), pick_elem(),
                           $urandom, $urandom));
          issue(make_req(MODE_ADVANCE, $urandom_range(3), $urandom_range(255),
                         $urandom_range(63), $urandom, $urandom));
        end
        6, 7, 8, 9, 10, 11: begin
          repeat ($urandom_range(1, 6)) begin
            r = make_req(MODE_READ, pick_layer(), pick_offset(), pick_elem(),
                         $urandom, $urandom);
            for (int t = 0; t < 3 && !sb.read_is_safe(r); t++)
              r = make_req(MODE_READ, pick_layer(), pick_offset(), pick_elem(),
                           $urandom, $urandom);
            issue(r);
          end
        end
        12, 13: begin
          repeat ($urandom_range(1, sb.ring_len() / 2 + 2))
            issue(make_req(MODE_ADVANCE, $urandom_range(3), $urandom_range(255),
                           $urandom_range(63), $urandom, $urandom));
        end
        14: issue(make_req(MODE_CLEAR, $urandom_range(3), $urandom_range(255),
                           $urandom_range(63), $urandom, $urandom));
        15, 16, 17, 18: issue(make_req(2'($urandom_range(3)), pick_layer(), pick_offset(),
                                       pick_elem(), $urandom, $urandom));
        default: begin
          raw = {$urandom, $urandom, $urandom};
          r   = raw[$bits(req_t)-1:0];
          issue(r);
        end
      endcase
    end
  endtask

  initial begin
    sb            = new();
    idle_pct      = 35;
    items_sent    = 0;
    settings_used = 1;
    rst       = 1'b1;
    start     = 1'b0;
    req       = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: empty ring, extreme words, offset and invalid slot cases
    issue(make_req(MODE_READ, 0, 0, 0, '0, '0));
    issue(make_req(MODE_WRITE, 0, 0, 0, '0, '0));
    issue(make_req(MODE_WRITE, 3, 255, 63, '1, '1));
    issue(make_req(MODE_ADVANCE, 3, 255, 63, $urandom, $urandom));
    issue(make_req(MODE_READ, 0, 0, 0, '0, '0));
    issue(make_req(MODE_READ, 3, 0, 63, '0, '0));
    issue(make_req(MODE_READ, 0, 1, 0, '0, '0));
    issue(make_req(MODE_READ, 0, 255, 0, '0, '0));
    issue(make_req(MODE_ADVANCE, 0, 0, 0, '0, '0));
    issue(make_req(MODE_READ, 0, 1, 0, '0, '0));
    issue(make_req(MODE_CLEAR, 3, 255, 63, $urandom, $urandom));
    issue(make_req(MODE_READ, 0, 0, 0, '0, '0));

    // Narrow settings: check order, bad fields, wrap and saturation of a short ring
    configure(2, 5, 3);
    issue(make_req(MODE_WRITE, 2, 0, 0, $urandom, $urandom));
    issue(make_req(MODE_WRITE, 1, 0, 5, $urandom, $urandom));
    issue(make_req(MODE_READ, 3, 255, 63, '0, '0));
    issue(make_req(MODE_READ, 0, 255, 10, '0, '0));
    issue(make_req(MODE_WRITE, 1, 0, 4, 32'h8000_0001, 32'h7fff_fffe));
    repeat (4) issue(make_req(MODE_ADVANCE, 0, 0, 0, '0, '0));
    issue(make_req(MODE_READ, 1, 2, 4, '0, '0));
    issue(make_req(MODE_READ, 1, 0, 4, '0, '0));

    // All registers zero: every layer bad, ring of one slot
    configure(0, 0, 0);
    issue(make_req(MODE_WRITE, 0, 0, 0, $urandom, $urandom));
    issue(make_req(MODE_ADVANCE, 0, 0, 0, '0, '0));

    configure(1, 4, 8);
    run_random(200);
    configure(2, 8, 16);
    run_random(100);
    drain();
    run_random(100);

    // Back-to-back transfers with no idling at all
    idle_pct = 0;
    configure(4, 3, 5);
    run_random(250);
    idle_pct = 35;

    // Register values past the limits clamp to the full store
    configure(7, 127, 511);
    run_random(250);
    configure(1, 1, 256);
    run_random(250);
    configure(3, 2, 1);
    run_random(150);
    configure(4, 0, 9);
    run_random(60);
    configure(4, 64, 2);
    run_random(120);
    drain();
    set_reg(REG_UNUSED, $urandom_range(511));
    repeat (2) begin
      configure($urandom_range(7), $urandom_range(127), $urandom_range(511));
      run_random(120);
    end

    drain();
    repeat (5) @(posedge clk);
    $display("Covered %0d transfers under %0d register settings, %0d results checked.",
             items_sent, settings_used, sb.results_seen);
    $display("Status mix: ok %0d, bad layer %0d, bad element %0d, offset %0d, invalid %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_BAD_LAYER], sb.status_seen[ST_BAD_ELEM],
             sb.status_seen[ST_BAD_OFFSET], sb.status_seen[ST_INVALID]);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("[ring_kv_cache_store_core] OK");
    end else begin
      $display("[ring_kv_cache_store_core] ERROR");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #3000000;
    $display("[ring_kv_cache_store_core] ERROR");
    $finish;
  end

endmodule
